// ----- sv/transform_matrix_decompose_top_assert.svh -----
// Assertion macros for the transform decomposition pipeline.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef TRANSFORM_MATRIX_DECOMPOSE_TOP_ASSERT_SVH
`define TRANSFORM_MATRIX_DECOMPOSE_TOP_ASSERT_SVH

// same-cycle implication
`define TMD_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmd assertion failed");

// next-cycle implication
`define TMD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmd assertion failed");

`endif

// ----- sv/tmd_pkg.sv -----
// Shared constants for the transform decomposition pipeline.
// No dependencies.
package tmd_pkg;

    localparam int WORD_W     = 32;
    localparam int N_COL      = 3;
    localparam int N_COMP     = 9;
    localparam int IN_DATA_W  = 384;
    localparam int OUT_DATA_W = 256;
    localparam int VEC_W      = 96;   // three 32-bit words
    localparam int LEN_SQ_W   = 64;
    localparam int LEN_W      = 32;
    localparam int ANG_W      = 19;
    localparam int RES_W      = 249;  // packed result without padding

    // CORDIC datapath: Q.30 operands and angles
    localparam int ACC_W     = 34;
    localparam int ACC_FRAC  = 30;
    localparam int ANG_SHIFT = 14;
    localparam int TAB_LEN   = 30;

    localparam logic signed [ACC_W-1:0] PI_Q30  = 34'sd3373259426;
    localparam logic signed [ACC_W-1:0] ANG_RND = 34'sd8192;
    localparam logic signed [ANG_W-1:0] ANG_LIMIT = 19'sd205888;

    localparam logic signed [ACC_W-1:0] ATAN_TAB [TAB_LEN] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127,
        34'sd63,        34'sd31,        34'sd15,        34'sd7,
        34'sd3,         34'sd1
    };

endpackage

// ----- sv/tmd_isqrt_pipe.sv -----
// Pipelined integer square root (floor), one result bit per stage, with sideband.
// Standalone; used by the top level for column lengths and the hypotenuse.
module tmd_isqrt_pipe #(
    parameter int IN_W   = 64,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [IN_W-1:0]      rad      [LANES],
    input  logic [SIDE_W-1:0]    side_in,
    output logic [IN_W/2-1:0]    root     [LANES],
    output logic [SIDE_W-1:0]    side_out
);

    localparam int OUT_W = IN_W / 2;

    logic [IN_W-1:0]   rem_reg   [OUT_W][LANES];
    logic [IN_W-1:0]   rem_next  [OUT_W][LANES];
    logic [OUT_W-1:0]  root_reg  [OUT_W][LANES];
    logic [OUT_W-1:0]  root_next [OUT_W][LANES];
    logic [SIDE_W-1:0] side_reg  [OUT_W];
    logic [SIDE_W-1:0] side_next [OUT_W];

    // rem holds n - root^2; each stage tries one more root bit
    always_comb
    begin : stage_logic
        logic [IN_W-1:0]  r_cur;
        logic [OUT_W-1:0] q_cur;
        logic [IN_W:0]    trial;
        int               p;
        int               b;
        for (int s = 0; s < OUT_W; s++)
        begin
            p = (s > 0) ? s - 1 : 0;
            b = OUT_W - 1 - s;
            side_next[s] = (s == 0) ? side_in : side_reg[p];
            for (int l = 0; l < LANES; l++)
            begin
                r_cur = (s == 0) ? rad[l] : rem_reg[p][l];
                q_cur = (s == 0) ? '0 : root_reg[p][l];
                trial = ((IN_W+1)'(q_cur) << (b + 1)) | ((IN_W+1)'(1) << (2 * b));
                if ({1'b0, r_cur} >= trial)
                begin
                    rem_next[s][l]  = r_cur - trial[IN_W-1:0];
                    root_next[s][l] = q_cur | (OUT_W'(1) << b);
                end
                else
                begin
                    rem_next[s][l]  = r_cur;
                    root_next[s][l] = q_cur;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_next;
        end
    end

    assign root     = root_reg[OUT_W-1];
    assign side_out = side_reg[OUT_W-1];

endmodule

// ----- sv/tmd_cordic_pipe.sv -----
// Pipelined CORDIC atan2 in vectoring mode, several lanes, with sideband.
// Depends on tmd_pkg for the arctangent table and angle format.
module tmd_cordic_pipe #(
    parameter int FRAC_BITS = 16,
    parameter int STEPS     = 18,
    parameter int LANES     = 3,
    parameter int SIDE_W    = 1
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [FRAC_BITS+1:0]        y        [LANES],
    input  logic signed [FRAC_BITS+1:0]        x        [LANES],
    input  logic [SIDE_W-1:0]                  side_in,
    output logic signed [tmd_pkg::ANG_W-1:0]   angle    [LANES],
    output logic [SIDE_W-1:0]                  side_out
);

    localparam int AW     = tmd_pkg::ACC_W;
    localparam int PRE_SH = tmd_pkg::ACC_FRAC - FRAC_BITS;
    localparam int SIDE_D = STEPS + 2;

    logic signed [AW-1:0] px_reg [LANES];
    logic signed [AW-1:0] py_reg [LANES];
    logic signed [AW-1:0] pz_reg [LANES];
    logic                 pzero_reg [LANES];
    logic signed [AW-1:0] px_next [LANES];
    logic signed [AW-1:0] py_next [LANES];
    logic signed [AW-1:0] pz_next [LANES];
    logic                 pzero_next [LANES];

    logic signed [AW-1:0] sx_reg [STEPS][LANES];
    logic signed [AW-1:0] sy_reg [STEPS][LANES];
    logic signed [AW-1:0] sz_reg [STEPS][LANES];
    logic                 szero_reg [STEPS][LANES];
    logic signed [AW-1:0] sx_next [STEPS][LANES];
    logic signed [AW-1:0] sy_next [STEPS][LANES];
    logic signed [AW-1:0] sz_next [STEPS][LANES];
    logic                 szero_next [STEPS][LANES];

    logic signed [tmd_pkg::ANG_W-1:0] ang_reg  [LANES];
    logic signed [tmd_pkg::ANG_W-1:0] ang_next [LANES];
    logic [SIDE_W-1:0]                side_reg [SIDE_D];

    // scale to Q.30, fold the left half-plane by +-pi
    always_comb
    begin : pre_logic
        logic signed [AW-1:0] xs;
        logic signed [AW-1:0] ys;
        for (int l = 0; l < LANES; l++)
        begin
            xs = AW'(x[l]) <<< PRE_SH;
            ys = AW'(y[l]) <<< PRE_SH;
            pzero_next[l] = (x[l] == '0) && (y[l] == '0);
            if (xs < 0)
            begin
                pz_next[l] = (ys >= 0) ? tmd_pkg::PI_Q30 : -tmd_pkg::PI_Q30;
                px_next[l] = -xs;
                py_next[l] = -ys;
            end
            else
            begin
                pz_next[l] = '0;
                px_next[l] = xs;
                py_next[l] = ys;
            end
        end
    end

    always_comb
    begin : step_logic
        logic signed [AW-1:0] xc;
        logic signed [AW-1:0] yc;
        logic signed [AW-1:0] zc;
        logic                 zf;
        int                   p;
        for (int i = 0; i < STEPS; i++)
        begin
            p = (i > 0) ? i - 1 : 0;
            for (int l = 0; l < LANES; l++)
            begin
                xc = (i == 0) ? px_reg[l] : sx_reg[p][l];
                yc = (i == 0) ? py_reg[l] : sy_reg[p][l];
                zc = (i == 0) ? pz_reg[l] : sz_reg[p][l];
                zf = (i == 0) ? pzero_reg[l] : szero_reg[p][l];
                szero_next[i][l] = zf;
                if (yc > 0)
                begin
                    sx_next[i][l] = xc + (yc >>> i);
                    sy_next[i][l] = yc - (xc >>> i);
                    sz_next[i][l] = zc + tmd_pkg::ATAN_TAB[i];
                end
                else
                begin
                    sx_next[i][l] = xc - (yc >>> i);
                    sy_next[i][l] = yc + (xc >>> i);
                    sz_next[i][l] = zc - tmd_pkg::ATAN_TAB[i];
                end
            end
        end
    end

    // round Q.30 to Q.16, then clamp to +-pi; a zero input vector gives angle 0
    always_comb
    begin : out_logic
        logic signed [AW-1:0] zsum;
        logic signed [AW-1:0] zr;
        logic signed [AW-1:0] lim;
        lim = AW'(tmd_pkg::ANG_LIMIT);
        for (int l = 0; l < LANES; l++)
        begin
            zsum = sz_reg[STEPS-1][l] + tmd_pkg::ANG_RND;
            zr   = zsum >>> tmd_pkg::ANG_SHIFT;
            if (szero_reg[STEPS-1][l])
                ang_next[l] = '0;
            else if (zr > lim)
                ang_next[l] = tmd_pkg::ANG_LIMIT;
            else if (zr < -lim)
                ang_next[l] = -tmd_pkg::ANG_LIMIT;
            else
                ang_next[l] = zr[tmd_pkg::ANG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            pz_reg    <= pz_next;
            pzero_reg <= pzero_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            sz_reg    <= sz_next;
            szero_reg <= szero_next;
            ang_reg   <= ang_next;
            side_reg[0] <= side_in;
            for (int k = 1; k < SIDE_D; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign angle    = ang_reg;
    assign side_out = side_reg[SIDE_D-1];

endmodule

// ----- sv/transform_matrix_decompose_top.sv -----
// Channel  | Dir | Payload
// s_*      | in  | tdata: col0_x..col2_z, move_x..move_z, 32 bits each
// m_*      | out | tdata: pos, angles, scales; tuser: degenerate
//
// One transaction per cycle sustained while the skid register is empty. Pipeline
// depth is set by the 32-stage length square root, the FRAC_BITS+1 stage divider
// and hypotenuse root, and the CORDIC stages.
// Reset clears only valid bits. A stalled output parks one result in a skid
// register; the pipeline freezes only while that register is full.
// Depends on tmd_pkg, tmd_isqrt_pipe, tmd_cordic_pipe.
`include "transform_matrix_decompose_top_assert.svh"

module transform_matrix_decompose_top #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // col0_x, col0_y, col0_z, col1_x .. col2_z, move_x, move_y, move_z
    input  logic [tmd_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, zero pad
    output logic [tmd_pkg::OUT_DATA_W-1:0]     m_tdata,
    // degenerate
    output logic                               m_tuser
);

    localparam int W     = tmd_pkg::WORD_W;
    localparam int QB    = FRAC_BITS + 1;           // quotient bits
    localparam int UW    = FRAC_BITS + 2;           // signed unit component
    localparam int NUM_W = W + FRAC_BITS + 1;       // divider numerator
    localparam int HW    = 2 * FRAC_BITS + 2;       // hypotenuse radicand
    localparam int SQ_W  = 2 * FRAC_BITS + 1;
    localparam int VW    = tmd_pkg::VEC_W;
    localparam int HS_W  = 5 * UW + 2 * VW + 1;
    localparam int CS_W  = 2 * VW + 1;
    localparam int LAT   = 2 + tmd_pkg::LEN_W + 1 + QB + 1 + 2 + (FRAC_BITS + 1)
                           + (CORDIC_STEPS + 2);

    logic en;
    logic [LAT-1:0] vld_reg;

    // stage 1: squared magnitudes
    logic [tmd_pkg::LEN_SQ_W-1:0]  sq1_reg  [tmd_pkg::N_COMP];
    logic [tmd_pkg::LEN_SQ_W-1:0]  sq1_next [tmd_pkg::N_COMP];
    logic [tmd_pkg::IN_DATA_W-1:0] side1_reg;

    always_comb
    begin : sq_logic
        logic [W-1:0] a;
        for (int k = 0; k < tmd_pkg::N_COMP; k++)
        begin
            a = s_tdata[k*W+W-1] ? (~s_tdata[k*W +: W] + W'(1)) : s_tdata[k*W +: W];
            sq1_next[k] = {{W{1'b0}}, a} * {{W{1'b0}}, a};
        end
    end

    // stage 2: column sums
    logic [tmd_pkg::LEN_SQ_W-1:0]  sum2_reg [tmd_pkg::N_COL];
    logic [tmd_pkg::IN_DATA_W-1:0] side2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq1_reg   <= sq1_next;
            side1_reg <= s_tdata;
            for (int c = 0; c < tmd_pkg::N_COL; c++)
                sum2_reg[c] <= sq1_reg[3*c] + sq1_reg[3*c+1] + sq1_reg[3*c+2];
            side2_reg <= side1_reg;
        end
    end

    logic [tmd_pkg::LEN_W-1:0]     len_root [tmd_pkg::N_COL];
    logic [tmd_pkg::IN_DATA_W-1:0] side3_in;

    tmd_isqrt_pipe #(
        .IN_W   (tmd_pkg::LEN_SQ_W),
        .LANES  (tmd_pkg::N_COL),
        .SIDE_W (tmd_pkg::IN_DATA_W)
    ) u_len_sqrt (
        .clk      (clk),
        .en       (en),
        .rad      (sum2_reg),
        .side_in  (side2_reg),
        .root     (len_root),
        .side_out (side3_in)
    );

    // stage 3: divider numerators, |c| * 2^F + len/2
    logic [NUM_W-1:0]          d3_num_reg  [tmd_pkg::N_COMP];
    logic [NUM_W-1:0]          d3_num_next [tmd_pkg::N_COMP];
    logic [tmd_pkg::LEN_W-1:0] d3_len_reg  [tmd_pkg::N_COL];
    logic [tmd_pkg::N_COMP-1:0] d3_sgn_reg;
    logic [tmd_pkg::N_COMP-1:0] d3_sgn_next;
    logic [VW-1:0]             d3_move_reg;
    logic                      d3_degen_reg;

    always_comb
    begin : num_logic
        logic [W-1:0] a;
        logic [W-1:0] cv;
        for (int k = 0; k < tmd_pkg::N_COMP; k++)
        begin
            cv = side3_in[k*W +: W];
            a  = cv[W-1] ? (~cv + W'(1)) : cv;
            d3_sgn_next[k] = cv[W-1];
            d3_num_next[k] = (NUM_W'(a) << FRAC_BITS) + NUM_W'(len_root[k/3] >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d3_num_reg   <= d3_num_next;
            d3_len_reg   <= len_root;
            d3_sgn_reg   <= d3_sgn_next;
            d3_move_reg  <= side3_in[tmd_pkg::IN_DATA_W-1 -: VW];
            d3_degen_reg <= (len_root[0] == '0) || (len_root[1] == '0) ||
                            (len_root[2] == '0);
        end
    end

    // restoring divider, one quotient bit per stage
    logic [NUM_W-1:0]           dv_rem_reg   [QB][tmd_pkg::N_COMP];
    logic [NUM_W-1:0]           dv_rem_next  [QB][tmd_pkg::N_COMP];
    logic [QB-1:0]              dv_q_reg     [QB][tmd_pkg::N_COMP];
    logic [QB-1:0]              dv_q_next    [QB][tmd_pkg::N_COMP];
    logic [tmd_pkg::LEN_W-1:0]  dv_len_reg   [QB][tmd_pkg::N_COL];
    logic [tmd_pkg::LEN_W-1:0]  dv_len_next  [QB][tmd_pkg::N_COL];
    logic [tmd_pkg::N_COMP-1:0] dv_sgn_reg   [QB];
    logic [tmd_pkg::N_COMP-1:0] dv_sgn_next  [QB];
    logic [VW-1:0]              dv_move_reg  [QB];
    logic [VW-1:0]              dv_move_next [QB];
    logic                       dv_degen_reg [QB];
    logic                       dv_degen_next[QB];

    always_comb
    begin : div_logic
        logic [NUM_W-1:0]          r_cur;
        logic [QB-1:0]             q_cur;
        logic [NUM_W-1:0]          trial;
        logic [tmd_pkg::LEN_W-1:0] dl;
        int                        p;
        int                        b;
        for (int s = 0; s < QB; s++)
        begin
            p = (s > 0) ? s - 1 : 0;
            b = QB - 1 - s;
            dv_sgn_next[s]   = (s == 0) ? d3_sgn_reg : dv_sgn_reg[p];
            dv_move_next[s]  = (s == 0) ? d3_move_reg : dv_move_reg[p];
            dv_degen_next[s] = (s == 0) ? d3_degen_reg : dv_degen_reg[p];
            for (int c = 0; c < tmd_pkg::N_COL; c++)
                dv_len_next[s][c] = (s == 0) ? d3_len_reg[c] : dv_len_reg[p][c];
            for (int k = 0; k < tmd_pkg::N_COMP; k++)
            begin
                r_cur = (s == 0) ? d3_num_reg[k] : dv_rem_reg[p][k];
                q_cur = (s == 0) ? '0 : dv_q_reg[p][k];
                dl    = (s == 0) ? d3_len_reg[k/3] : dv_len_reg[p][k/3];
                trial = NUM_W'(dl) << b;
                if (r_cur >= trial)
                begin
                    dv_rem_next[s][k] = r_cur - trial;
                    dv_q_next[s][k]   = q_cur | (QB'(1) << b);
                end
                else
                begin
                    dv_rem_next[s][k] = r_cur;
                    dv_q_next[s][k]   = q_cur;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem_reg   <= dv_rem_next;
            dv_q_reg     <= dv_q_next;
            dv_len_reg   <= dv_len_next;
            dv_sgn_reg   <= dv_sgn_next;
            dv_move_reg  <= dv_move_next;
            dv_degen_reg <= dv_degen_next;
        end
    end

    // stage 4: signed unit components u00, u01, u02, u12, u22
    localparam int U_SEL [5] = '{0, 1, 2, 5, 8};

    logic [5*UW-1:0] u4_reg;
    logic [5*UW-1:0] u4_next;
    logic [VW-1:0]   scale4_reg;
    logic [VW-1:0]   move4_reg;
    logic            degen4_reg;

    always_comb
    begin : unit_logic
        logic signed [UW-1:0] qs;
        int                   k;
        for (int i = 0; i < 5; i++)
        begin
            k  = U_SEL[i];
            qs = $signed(UW'(dv_q_reg[QB-1][k]));
            if (dv_len_reg[QB-1][k/3] == '0)
                u4_next[i*UW +: UW] = '0;
            else if (dv_sgn_reg[QB-1][k])
                u4_next[i*UW +: UW] = -qs;
            else
                u4_next[i*UW +: UW] = qs;
        end
    end

    // stages 5 and 6: u12^2 + u22^2
    logic [SQ_W-1:0] hsq5_reg [2];
    logic [SQ_W-1:0] hsq5_next [2];
    logic [5*UW-1:0] u5_reg;
    logic [VW-1:0]   scale5_reg;
    logic [VW-1:0]   move5_reg;
    logic            degen5_reg;
    logic [HW-1:0]   hsum6_reg [1];
    logic [5*UW-1:0] u6_reg;
    logic [VW-1:0]   scale6_reg;
    logic [VW-1:0]   move6_reg;
    logic            degen6_reg;

    always_comb
    begin : hsq_logic
        logic signed [UW-1:0]   uv;
        logic signed [2*UW-1:0] prod;
        for (int i = 0; i < 2; i++)
        begin
            uv   = $signed(u4_reg[(3+i)*UW +: UW]);
            prod = uv * uv;
            hsq5_next[i] = prod[SQ_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u4_reg     <= u4_next;
            for (int c = 0; c < tmd_pkg::N_COL; c++)
                scale4_reg[c*W +: W] <= dv_len_reg[QB-1][c];
            move4_reg  <= dv_move_reg[QB-1];
            degen4_reg <= dv_degen_reg[QB-1];

            hsq5_reg   <= hsq5_next;
            u5_reg     <= u4_reg;
            scale5_reg <= scale4_reg;
            move5_reg  <= move4_reg;
            degen5_reg <= degen4_reg;

            hsum6_reg[0] <= HW'(hsq5_reg[0]) + HW'(hsq5_reg[1]);
            u6_reg     <= u5_reg;
            scale6_reg <= scale5_reg;
            move6_reg  <= move5_reg;
            degen6_reg <= degen5_reg;
        end
    end

    logic [FRAC_BITS:0] hyp_root [1];
    logic [HS_W-1:0]    side7;

    tmd_isqrt_pipe #(
        .IN_W   (HW),
        .LANES  (1),
        .SIDE_W (HS_W)
    ) u_hyp_sqrt (
        .clk      (clk),
        .en       (en),
        .rad      (hsum6_reg),
        .side_in  ({degen6_reg, scale6_reg, move6_reg, u6_reg}),
        .root     (hyp_root),
        .side_out (side7)
    );

    logic signed [UW-1:0] cy [3];
    logic signed [UW-1:0] cx [3];
    logic signed [tmd_pkg::ANG_W-1:0] ang [3];
    logic [CS_W-1:0] side_end;

    always_comb
    begin
        cy[0] = $signed(side7[3*UW +: UW]);            // u12
        cx[0] = $signed(side7[4*UW +: UW]);            // u22
        cy[1] = -$signed(side7[2*UW +: UW]);           // -u02
        cx[1] = $signed({1'b0, hyp_root[0]});
        cy[2] = $signed(side7[1*UW +: UW]);            // u01
        cx[2] = $signed(side7[0 +: UW]);               // u00
    end

    tmd_cordic_pipe #(
        .FRAC_BITS (FRAC_BITS),
        .STEPS     (CORDIC_STEPS),
        .LANES     (3),
        .SIDE_W    (CS_W)
    ) u_cordic (
        .clk      (clk),
        .en       (en),
        .y        (cy),
        .x        (cx),
        .side_in  (side7[HS_W-1 -: CS_W]),
        .angle    (ang),
        .side_out (side_end)
    );

    // result: move, angles, scales (low to high); degenerate on top bit of side
    logic [tmd_pkg::RES_W-1:0] res_data;
    logic                      res_user;

    assign res_data = {side_end[CS_W-2 -: VW], ang[2], ang[1], ang[0], side_end[VW-1:0]};
    assign res_user = side_end[CS_W-1];

    // output register plus one skid entry
    logic                      out_v_reg;
    logic                      hold_v_reg;
    logic [tmd_pkg::RES_W-1:0] out_data_reg;
    logic                      out_user_reg;
    logic [tmd_pkg::RES_W-1:0] hold_data_reg;
    logic                      hold_user_reg;
    logic                      pop;
    logic                      last_v;

    assign en       = !hold_v_reg;
    assign s_tready = en;
    assign pop      = out_v_reg && m_tready;
    assign last_v   = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            out_v_reg  <= 1'b0;
            hold_v_reg <= 1'b0;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            priority if (hold_v_reg && pop)
            begin
                hold_v_reg <= 1'b0;
            end
            else if (en && last_v && (!out_v_reg || pop))
            begin
                out_v_reg <= 1'b1;
            end
            else if (en && last_v)
            begin
                hold_v_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= out_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (hold_v_reg && pop)
        begin
            out_data_reg <= hold_data_reg;
            out_user_reg <= hold_user_reg;
        end
        else if (en && last_v && (!out_v_reg || pop))
        begin
            out_data_reg <= res_data;
            out_user_reg <= res_user;
        end
        else if (en && last_v)
        begin
            hold_data_reg <= res_data;
            hold_user_reg <= res_user;
        end
        else
        begin
            out_data_reg <= out_data_reg;
            out_user_reg <= out_user_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {(tmd_pkg::OUT_DATA_W - tmd_pkg::RES_W)'(0), out_data_reg};
    assign m_tuser  = out_user_reg;

    `TMD_ASSERT_IMPLY(a_hold_needs_out, hold_v_reg, out_v_reg)
    `TMD_ASSERT_NEXT(a_stall_freezes_pipe, !en, $stable(vld_reg))
    `TMD_ASSERT_NEXT(a_hold_drains, hold_v_reg && m_tready, out_v_reg && !hold_v_reg)
    `TMD_ASSERT_NEXT(a_exit_lands, en && last_v, out_v_reg)

endmodule

// ----- bench/tb.sv -----
// Testbench for transform_matrix_decompose_top: streams random and corner-case
// affine matrices and checks every result against a built-in predictor.
// Depends on tmd_pkg and the RTL of transform_matrix_decompose_top.
`timescale 1ns / 100ps

typedef struct {
    logic [31:0]        pos_x, pos_y, pos_z;
    logic signed [18:0] angle_x, angle_y, angle_z;
    logic [31:0]        scale_x, scale_y, scale_z;
    logic               degenerate;
} decomp_t;

class decomp_scoreboard;
    localparam int FRAC = 16;
    localparam int STEPS = 18;
    decomp_t pending[$];
    int errors;
    int matched;

    function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function longint unsigned root64(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function longint unit_of(longint c, longint unsigned len);
        longint unsigned m;
        longint unsigned q;
        if (len == 0) return 0;
        m = (c < 0) ? -c : c;
        q = ((m << FRAC) + (len >> 1)) / len;
        if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint vector_angle(longint y, longint x);
        longint z;
        longint nx;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * (64'sd1 <<< (30 - FRAC));
        y = y * (64'sd1 <<< (30 - FRAC));
        if (x < 0)
        begin
            z = (y >= 0) ? tmd_pkg::PI_Q30 : -longint'(tmd_pkg::PI_Q30);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z = z + tmd_pkg::ATAN_TAB[i];
            end
            else
            begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z = z - tmd_pkg::ATAN_TAB[i];
            end
            x = nx;
        end
        z = floor_shift(z + 8192, 14);
        if (z > 205888) z = 205888;
        if (z < -205888) z = -205888;
        return z;
    endfunction

    function void note_input(logic [383:0] d);
        longint c[3][3];
        longint u[3][3];
        longint unsigned len[3];
        longint unsigned sum;
        longint hyp;
        decomp_t e;
        e.degenerate = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            sum = 0;
            for (int j = 0; j < 3; j++)
            begin
                c[k][j] = longint'($signed(d[(k*3+j)*32 +: 32]));
                sum = sum + longint'(c[k][j] * c[k][j]);
            end
            len[k] = root64(sum);
            if (len[k] > 64'hFFFFFFFF) len[k] = 64'hFFFFFFFF;
            if (len[k] == 0) e.degenerate = 1'b1;
            for (int j = 0; j < 3; j++) u[k][j] = unit_of(c[k][j], len[k]);
        end
        hyp = root64(u[1][2] * u[1][2] + u[2][2] * u[2][2]);
        e.pos_x = d[288 +: 32];
        e.pos_y = d[320 +: 32];
        e.pos_z = d[352 +: 32];
        e.angle_x = 19'(vector_angle(u[1][2], u[2][2]));
        e.angle_y = 19'(vector_angle(-u[0][2], hyp));
        e.angle_z = 19'(vector_angle(u[0][1], u[0][0]));
        e.scale_x = 32'(len[0]);
        e.scale_y = 32'(len[1]);
        e.scale_z = 32'(len[2]);
        pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, matched);
        errors++;
    endtask

    task check_result(logic [255:0] d, logic u);
        decomp_t e;
        if (pending.size() == 0)
        begin
            $display("unexpected result transaction");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d[31:0] !== e.pos_x) report("pos_x", d[31:0], e.pos_x);
        if (d[63:32] !== e.pos_y) report("pos_y", d[63:32], e.pos_y);
        if (d[95:64] !== e.pos_z) report("pos_z", d[95:64], e.pos_z);
        if (d[114:96] !== e.angle_x) report("angle_x", $signed(d[114:96]), e.angle_x);
        if (d[133:115] !== e.angle_y) report("angle_y", $signed(d[133:115]), e.angle_y);
        if (d[152:134] !== e.angle_z) report("angle_z", $signed(d[152:134]), e.angle_z);
        if (d[184:153] !== e.scale_x) report("scale_x", d[184:153], e.scale_x);
        if (d[216:185] !== e.scale_y) report("scale_y", d[216:185], e.scale_y);
        if (d[248:217] !== e.scale_z) report("scale_z", d[248:217], e.scale_z);
        if (u !== e.degenerate) report("degenerate", u, e.degenerate);
        matched++;
    endtask
endclass

module tb;
    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [383:0] s_tdata;   // col0_x .. col2_z, move_x, move_y, move_z
    logic m_tvalid;
    logic m_tready;
    logic [255:0] m_tdata;   // pos, angles, scales, zero pad
    logic m_tuser;           // degenerate

    int send_idle;
    int recv_idle;
    bit hold_recv;
    int accepted;
    decomp_scoreboard board;

    transform_matrix_decompose_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("timeout");
        $display("FAIL transform_matrix_decompose_top");
        $finish;
    end

    // receiver side; also the scoreboard check
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
        if (rst_n && s_tvalid && s_tready) accepted++;
        m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom_range(255) - 128;
            4: return 32'(int'($urandom_range(1 << 18)) - (1 << 17));
            default: return $urandom;
        endcase
    endfunction

    // valid stays up between back-to-back transactions; drain drops it
    task automatic send_item(logic [383:0] d);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_input(d);
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        while (n < 120)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    task automatic random_items(int count);
        logic [383:0] d;
        for (int i = 0; i < count; i++)
        begin
            for (int w = 0; w < 12; w++) d[w*32 +: 32] = pick_word();
            if ($urandom_range(9) == 0) d[$urandom_range(2)*96 +: 96] = '0;
            send_item(d);
        end
    endtask

    initial
    begin
        logic [383:0] d;
        board = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        hold_recv = 0;
        accepted = 0;
        send_idle = 0;
        recv_idle = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: identity, extremes, zero columns, negative-x atan cases
        d = '0;
        d[0 +: 32] = 32'h10000; d[128 +: 32] = 32'h10000; d[256 +: 32] = 32'h10000;
        send_item(d);
        send_item('0);
        send_item({12{32'h8000_0000}});
        send_item({12{32'h7FFF_FFFF}});
        send_item({12{32'hFFFF_FFFF}});
        send_item({12{32'h0000_0001}});
        d = '0; d[0 +: 32] = -32'sh20000; d[192 +: 32] = -32'sh10000;
        d[256 +: 32] = 32'h10000; send_item(d);
        d = '0; d[0 +: 32] = -32'sh10000; d[32 +: 32] = 32'h30000; d[64 +: 32] = 32'h10000;
        d[96 +: 32] = 32'h10000; d[256 +: 32] = -32'sh10000; send_item(d);
        d = '0; d[64 +: 32] = 32'h10000; d[160 +: 32] = 32'h8000_0000;
        d[224 +: 32] = 32'h10000; send_item(d);
        d = {12{32'hAAAA_5555}}; send_item(d);
        d = {12{32'h5555_AAAA}}; send_item(d);
        drain();

        send_idle = 23; recv_idle = 79;
        random_items(500);
        send_idle = 79; recv_idle = 23;
        random_items(400);
        send_idle = 0; recv_idle = 0;
        random_items(300);

        // long receiver hold while input keeps offering, to back up the pipe
        fork
            begin
                hold_recv = 1;
                repeat (400) @(posedge clk);
                hold_recv = 0;
            end
            random_items(250);
        join
        drain();   // sender waits for every outstanding result
        random_items(250);
        drain();

        $display("covered %0d input transactions, %0d results checked,",
                 accepted, board.matched);
        $display("with directed corners, zero columns, idling and a long output stall");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS transform_matrix_decompose_top");
        else
            $display("FAIL transform_matrix_decompose_top");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+sv
sv/tmd_pkg.sv
sv/tmd_isqrt_pipe.sv
sv/tmd_cordic_pipe.sv
sv/transform_matrix_decompose_top.sv
bench/tb.sv
